// ===== rtl/core/mtds_pkg.sv =====
// ----------------------------------------------------------------------------
// mtds_pkg
// Types and constants shared by the text display scanner modules.
// ----------------------------------------------------------------------------
package mtds_pkg;

  // Display geometry
  localparam int unsigned CHARS_PER_INDICATOR = 8;
  localparam int unsigned MAX_INDICATORS      = 8;
  localparam int unsigned MAX_ROWS            = 7;
  localparam int unsigned SCAN_COLUMNS        = 5;

  localparam int unsigned ROW_LEN_MAX = CHARS_PER_INDICATOR * MAX_INDICATORS;
  localparam int unsigned TEXT_DEPTH  = MAX_ROWS * ROW_LEN_MAX;
  localparam int unsigned FONT_CODES  = 64;
  localparam int unsigned FONT_DEPTH  = SCAN_COLUMNS * FONT_CODES;
  localparam int unsigned DOTS        = 7;

  localparam int unsigned TEXT_AW = $clog2(TEXT_DEPTH);
  localparam int unsigned FONT_AW = $clog2(FONT_DEPTH);
  localparam int unsigned LEN_W   = $clog2(ROW_LEN_MAX + 1);

  localparam logic [5:0] SPACE_CODE = 6'd32;

  // Item commands
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;
  localparam logic [1:0] CMD_FONT  = 2'd3;

  // Write status codes
  localparam logic [1:0] WS_ACCEPTED = 2'd0;
  localparam logic [1:0] WS_RANGE    = 2'd1;
  localparam logic [1:0] WS_IGNORED  = 2'd2;

  // Register indexes
  localparam logic [1:0] REG_ROW_COUNT  = 2'd0;
  localparam logic [1:0] REG_INDICATORS = 2'd1;
  localparam logic [1:0] REG_UNUSED     = 2'd2;

  typedef struct packed {
    logic [1:0] command;
    logic [5:0] text_column;
    logic [2:0] text_row;
    logic [5:0] char_code;
    logic [2:0] font_column;
    logic [6:0] font_bits;
    logic       string_end;
  } mtds_in_t;

  typedef struct packed {
    logic [7:0] pin_byte;
    logic [2:0] scan_column;
    logic       column_done;
    logic [1:0] write_status;
    logic [6:0] accepted_count;
  } mtds_out_t;

  typedef struct packed {
    logic [2:0] row_count;
    logic [3:0] indicators_per_row;
    logic [7:0] unused_pins_value;
  } mtds_cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic latch;       // capture accepted word
    logic init_step;   // clearing pass after reset
    logic clear_step;  // clear command sweep
    logic exec;        // write or font load
    logic tick_issue;  // issue one row read
    logic tick_end;    // form pin byte, advance scan
    logic out_load;    // move result to output register
  } mtds_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [1:0] command;
    logic       last_row;
    logic       clear_last;
    logic       init_last;
  } mtds_sts_t;

endpackage

// ===== rtl/core/multiplexed_text_display_scanner.sv =====
// ----------------------------------------------------------------------------
// multiplexed_text_display_scanner
// Scans a multiplexed 5-column dot text display from text and font stores.
// ----------------------------------------------------------------------------
// After reset the block writes spaces into the whole text store and stalls
// its input meanwhile; register writes are taken throughout. Each word then
// yields one result word. With the output free, a tick runs the execute
// state, an issue state per row, the drain states, the end state and the
// finish state, rows being row_count clamped to 1..7. The walk is set by the
// single read port of the text store and of the font store, which every row
// passes in turn through a three-stage read pipeline. A character write or a
// font load runs the execute state, then the finish state. A clear writes
// rows * indicators * 8 text store entries, one entry per cycle, with
// indicators_per_row clamped to 1..8. The input stays stalled from acceptance
// until the result is in the output register; a result waiting there stalls
// the input only when the next result is ready and the output is still stalled.
module multiplexed_text_display_scanner (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  mtds_pkg::mtds_in_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output mtds_pkg::mtds_out_t  out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import mtds_pkg::*;

  mtds_cfg_t  cfg_r;
  mtds_cmd_t  cmd;
  mtds_sts_t  sts;
  logic [1:0] reg_idx;
  logic       reg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign reg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.row_count          <= 3'd1;
      cfg_r.indicators_per_row <= 4'd1;
      cfg_r.unused_pins_value  <= 8'd0;
    end else if (reg_wr) begin
      unique case (reg_idx)
        REG_ROW_COUNT:  cfg_r.row_count          <= pwdata[2:0];
        REG_INDICATORS: cfg_r.indicators_per_row <= pwdata[3:0];
        REG_UNUSED:     cfg_r.unused_pins_value  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ROW_COUNT:  prdata = 32'(cfg_r.row_count);
      REG_INDICATORS: prdata = 32'(cfg_r.indicators_per_row);
      REG_UNUSED:     prdata = 32'(cfg_r.unused_pins_value);
      default:        prdata = '0;
    endcase
  end

  mtds_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  mtds_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

// ===== rtl/core/mtds_ctrl.sv =====
// ----------------------------------------------------------------------------
// mtds_ctrl
// Sequencer: reset clearing pass, item dispatch, row walk and result handoff.
// ----------------------------------------------------------------------------
module mtds_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output mtds_pkg::mtds_cmd_t cmd,
  input  mtds_pkg::mtds_sts_t sts
);
  import mtds_pkg::*;

  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_EXEC   = 4'd2;
  localparam logic [3:0] S_CLEAR  = 4'd3;
  localparam logic [3:0] S_ISSUE  = 4'd4;
  localparam logic [3:0] S_DRAIN1 = 4'd5;
  localparam logic [3:0] S_DRAIN2 = 4'd6;
  localparam logic [3:0] S_TEND   = 4'd7;
  localparam logic [3:0] S_FINISH = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_INIT: begin
        cmd.init_step = 1'b1;
        if (sts.init_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (sts.command) inside
          CMD_WRITE, CMD_FONT: begin
            cmd.exec  = 1'b1;
            state_nxt = S_FINISH;
          end
          CMD_CLEAR: state_nxt = S_CLEAR;
          default:   state_nxt = S_ISSUE;
        endcase
      end
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_last) state_nxt = S_FINISH;
      end
      S_ISSUE: begin
        cmd.tick_issue = 1'b1;
        if (sts.last_row) state_nxt = S_DRAIN1;
      end
      S_DRAIN1: state_nxt = S_DRAIN2;
      S_DRAIN2: state_nxt = S_TEND;
      S_TEND: begin
        cmd.tick_end = 1'b1;
        state_nxt    = S_FINISH;
      end
      S_FINISH: begin
        // hold the result until the output register frees up
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load)       out_valid_nxt = 1'b1;
    else if (!out_stall)    out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTH
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_EXEC))
    else $error("accepted word did not start execution");

  a_finish_hands_off: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH && out_free) |=> (out_valid_r && state_r == S_IDLE))
    else $error("result not handed to output register");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> out_free)
    else $error("output register overwritten while stalled");
`endif

endmodule

// ===== rtl/core/mtds_dp.sv =====
// ----------------------------------------------------------------------------
// mtds_dp
// Datapath: text and font stores, scan counters, write string tracking and
// the per-row read pipeline that builds one pin byte.
// ----------------------------------------------------------------------------
module mtds_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  mtds_pkg::mtds_cfg_t cfg,
  input  mtds_pkg::mtds_in_t  in_data,
  input  mtds_pkg::mtds_cmd_t cmd,
  output mtds_pkg::mtds_sts_t sts,
  output mtds_pkg::mtds_out_t out_data
);
  import mtds_pkg::*;

  logic [5:0] text_mem [0:TEXT_DEPTH-1];
  logic [6:0] font_mem [0:FONT_DEPTH-1];

  mtds_in_t   item_r;
  mtds_out_t  res_r, res_nxt, out_r, idle_res;

  logic [2:0]         column_r, column_nxt;
  logic [5:0]         cc_r, cc_nxt;
  logic [2:0]         dot_r, dot_nxt;
  logic               strobe_r, strobe_nxt;
  logic [6:0]         sa_r, sa_nxt;
  logic               stopped_r, stopped_nxt;
  logic [TEXT_AW-1:0] clr_ptr_r, clr_ptr_nxt;
  logic [2:0]         rr_r;
  logic               v1_r, v2_r;
  logic [2:0]         row1_r, row2_r;
  logic [5:0]         text_q_r;
  logic [6:0]         font_q_r;
  logic [6:0]         acc_r;

  logic [2:0]         rows_eff;
  logic [3:0]         ind_eff;
  logic [LEN_W-1:0]   len;
  logic [TEXT_AW-1:0] clear_total;
  logic [5:0]         cc_eff;
  logic [5:0]         pos_tick;
  logic [6:0]         cc_inc;
  logic [7:0]         pos_wr;
  logic               wr_range_bad;
  logic [TEXT_AW-1:0] wr_addr;
  logic [TEXT_AW-1:0] text_ra, text_wa;
  logic [5:0]         text_wd;
  logic               text_we;
  logic [FONT_AW-1:0] font_ra, font_wa;
  logic               font_we;
  logic [7:0]         unused_mask;
  logic [7:0]         pin_byte;
  logic [1:0]         wr_status;

  // Effective geometry from the live registers
  always_comb begin
    rows_eff = cfg.row_count;
    if (cfg.row_count == 3'd0) rows_eff = 3'd1;
    else if (32'(cfg.row_count) > MAX_ROWS) rows_eff = 3'(MAX_ROWS);
    ind_eff = cfg.indicators_per_row;
    if (cfg.indicators_per_row == 4'd0) ind_eff = 4'd1;
    else if (32'(cfg.indicators_per_row) > MAX_INDICATORS) ind_eff = 4'(MAX_INDICATORS);
  end

  assign len         = LEN_W'(ind_eff * CHARS_PER_INDICATOR);
  assign clear_total = TEXT_AW'(rows_eff * len);

  // A counter left past a shrunk row restarts at the first position
  assign cc_eff   = ({1'b0, cc_r} >= len) ? 6'd0 : cc_r;
  assign pos_tick = 6'(len - LEN_W'(1) - LEN_W'(cc_eff));
  assign cc_inc   = 7'(cc_eff) + 7'd1;

  assign text_ra = TEXT_AW'(rr_r * len) + TEXT_AW'(pos_tick);
  assign font_ra = FONT_AW'(column_r * FONT_CODES) + FONT_AW'(text_q_r);

  assign pos_wr       = 8'(item_r.text_column) + 8'(sa_r);
  assign wr_range_bad = (item_r.text_row >= rows_eff) || (pos_wr >= 8'(len));
  assign wr_addr      = TEXT_AW'(item_r.text_row * len) + TEXT_AW'(pos_wr);
  assign font_wa      = FONT_AW'(item_r.font_column * FONT_CODES) + FONT_AW'(item_r.char_code);

  assign unused_mask = 8'(8'hFF << (4'(rows_eff) + 4'd1));
  assign pin_byte    = (cfg.unused_pins_value & unused_mask) | {acc_r, 1'b0}
                     | {7'd0, ~strobe_r};

  assign sts.command    = item_r.command;
  assign sts.last_row   = (rr_r == rows_eff - 3'd1);
  assign sts.clear_last = (clr_ptr_r == clear_total - TEXT_AW'(1));
  assign sts.init_last  = (32'(clr_ptr_r) == TEXT_DEPTH - 1);

  assign out_data = out_r;

  always_comb begin
    idle_res                = '0;
    idle_res.scan_column    = column_r;
    idle_res.write_status   = WS_ACCEPTED;
  end

  always_comb begin
    column_nxt  = column_r;
    cc_nxt      = cc_r;
    dot_nxt     = dot_r;
    strobe_nxt  = strobe_r;
    sa_nxt      = sa_r;
    stopped_nxt = stopped_r;
    clr_ptr_nxt = clr_ptr_r;
    res_nxt     = res_r;
    text_we     = 1'b0;
    text_wa     = clr_ptr_r;
    text_wd     = SPACE_CODE;
    font_we     = 1'b0;
    wr_status   = WS_ACCEPTED;

    if (cmd.init_step) begin
      text_we     = 1'b1;
      clr_ptr_nxt = sts.init_last ? '0 : clr_ptr_r + TEXT_AW'(1);
    end

    if (cmd.clear_step) begin
      text_we     = 1'b1;
      clr_ptr_nxt = sts.clear_last ? '0 : clr_ptr_r + TEXT_AW'(1);
      if (sts.clear_last) res_nxt = idle_res;
    end

    if (cmd.exec) begin
      res_nxt = idle_res;
      if (item_r.command == CMD_WRITE) begin
        if (stopped_r) begin
          wr_status = WS_IGNORED;
        end else if (item_r.char_code == 6'd0) begin
          stopped_nxt = 1'b1;
          wr_status   = WS_IGNORED;
        end else if (wr_range_bad) begin
          wr_status = WS_RANGE;
        end else begin
          text_we = 1'b1;
          text_wa = wr_addr;
          text_wd = item_r.char_code;
          sa_nxt  = sa_r + 7'd1;
        end
        res_nxt.write_status   = wr_status;
        res_nxt.accepted_count = sa_nxt;
        // drop string tracking after its last word
        if (item_r.string_end) begin
          sa_nxt      = '0;
          stopped_nxt = 1'b0;
        end
      end else begin
        font_we = (32'(item_r.font_column) < SCAN_COLUMNS);
      end
    end

    if (cmd.tick_end) begin
      res_nxt          = idle_res;
      res_nxt.pin_byte = pin_byte;
      cc_nxt           = cc_eff;
      if (!strobe_r) begin
        strobe_nxt = 1'b1;
      end else begin
        strobe_nxt = 1'b0;
        if (dot_r == 3'(DOTS - 1)) begin
          dot_nxt = '0;
          if (cc_inc >= 7'(len)) begin
            cc_nxt              = '0;
            res_nxt.column_done = 1'b1;
            column_nxt = (column_r == 3'(SCAN_COLUMNS - 1)) ? 3'd0 : column_r + 3'd1;
          end else begin
            cc_nxt = cc_inc[5:0];
          end
        end else begin
          dot_nxt = dot_r + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r  <= '0;
      cc_r      <= '0;
      dot_r     <= '0;
      strobe_r  <= 1'b0;
      sa_r      <= '0;
      stopped_r <= 1'b0;
      clr_ptr_r <= '0;
      rr_r      <= '0;
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
    end else begin
      column_r  <= column_nxt;
      cc_r      <= cc_nxt;
      dot_r     <= dot_nxt;
      strobe_r  <= strobe_nxt;
      sa_r      <= sa_nxt;
      stopped_r <= stopped_nxt;
      clr_ptr_r <= clr_ptr_nxt;
      v1_r      <= cmd.tick_issue;
      v2_r      <= v1_r;
      if (cmd.latch)           rr_r <= '0;
      else if (cmd.tick_issue) rr_r <= rr_r + 3'd1;
    end
  end

  // Payload registers and the row pipeline
  always_ff @(posedge clk) begin
    if (cmd.latch) item_r <= in_data;
    res_r  <= res_nxt;
    if (cmd.out_load) out_r <= res_r;
    row1_r <= rr_r;
    row2_r <= row1_r;
    if (cmd.latch)   acc_r         <= '0;
    else if (v2_r)   acc_r[row2_r] <= font_q_r[dot_r];
  end

  always_ff @(posedge clk) begin
    if (text_we) text_mem[text_wa] <= text_wd;
    text_q_r <= text_mem[text_ra];
  end

  always_ff @(posedge clk) begin
    if (font_we) font_mem[font_wa] <= item_r.font_bits;
    font_q_r <= font_mem[font_ra];
  end

`ifndef SYNTH
  a_column_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(column_r) < SCAN_COLUMNS)
    else $error("scan column out of range");

  a_row_pipe_range: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> (row2_r < rows_eff))
    else $error("row pipeline carries an unused row");

  a_text_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
    text_we |-> (32'(text_wa) < TEXT_DEPTH))
    else $error("text store write beyond depth");
`endif

endmodule

// ===== tb/multiplexed_text_display_scanner_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multiplexed_text_display_scanner_tb
// Self-checking bench for the text display scanner. Fills the font store,
// runs a directed sequence, then random words through several register
// settings and handshake pressure modes, checking every result word against
// a cycle-free prediction of the scan, write and clear behavior.
// ----------------------------------------------------------------------------
module multiplexed_text_display_scanner_tb;
  import mtds_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASES         = 8;
  localparam int PHASE_WORDS    = 70;

  class pin_scoreboard;
    int rows_reg, ind_reg, unused_reg;
    int col_idx, char_ctr, dot_ctr, strobe;
    int str_count, str_stopped;
    logic [5:0] text_mem [0:TEXT_DEPTH-1];
    logic [6:0] font_mem [0:FONT_DEPTH-1];
    mtds_out_t predicted_pins[$];
    int mismatches;

    function new();
      rows_reg = 1;
      ind_reg = 1;
      unused_reg = 0;
      col_idx = 0;
      char_ctr = 0;
      dot_ctr = 0;
      strobe = 0;
      str_count = 0;
      str_stopped = 0;
      mismatches = 0;
      foreach (text_mem[i]) text_mem[i] = SPACE_CODE;
      foreach (font_mem[i]) font_mem[i] = '0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        REG_ROW_COUNT:  rows_reg = int'(val[2:0]);
        REG_INDICATORS: ind_reg = int'(val[3:0]);
        REG_UNUSED:     unused_reg = int'(val[7:0]);
        default: ;
      endcase
    endfunction

    function int eff_rows();
      if (rows_reg < 1) return 1;
      if (rows_reg > MAX_ROWS) return MAX_ROWS;
      return rows_reg;
    endfunction

    function int row_len();
      int n;
      n = ind_reg;
      if (n < 1) n = 1;
      if (n > MAX_INDICATORS) n = MAX_INDICATORS;
      return n * CHARS_PER_INDICATOR;
    endfunction

    // Pin levels for the current scan position
    function int pin_level();
      int rows, len, pos, b, code, dots;
      rows = eff_rows();
      len = row_len();
      pos = len - 1 - char_ctr;
      b = unused_reg & ((32'hFF << (rows + 1)) & 32'hFF);
      for (int r = 0; r < rows; r++) begin
        code = int'(text_mem[r * len + pos]);
        dots = int'(font_mem[col_idx * FONT_CODES + code]);
        b = b | (((dots >> dot_ctr) & 1) << (1 + r));
      end
      if (strobe == 0) b = b | 1;
      return b & 32'hFF;
    endfunction

    function void note_word(mtds_in_t w);
      mtds_out_t r;
      int len, pos, total;
      r = '0;
      r.scan_column = 3'(col_idx);
      len = row_len();
      case (w.command)
        CMD_TICK: begin
          if (char_ctr >= len) char_ctr = 0;
          r.pin_byte = 8'(pin_level());
          if (strobe == 0) begin
            strobe = 1;
          end else begin
            strobe = 0;
            dot_ctr++;
            if (dot_ctr >= DOTS) begin
              dot_ctr = 0;
              char_ctr++;
              if (char_ctr >= len) begin
                char_ctr = 0;
                r.column_done = 1'b1;
                col_idx++;
                if (col_idx >= SCAN_COLUMNS) col_idx = 0;
              end
            end
          end
        end
        CMD_WRITE: begin
          pos = int'(w.text_column) + str_count;
          if (str_stopped != 0) begin
            r.write_status = WS_IGNORED;
          end else if (w.char_code == 6'd0) begin
            str_stopped = 1;
            r.write_status = WS_IGNORED;
          end else if (int'(w.text_row) >= eff_rows() || pos >= len) begin
            r.write_status = WS_RANGE;
          end else begin
            text_mem[int'(w.text_row) * len + pos] = w.char_code;
            str_count = (str_count + 1) & 127;
            r.write_status = WS_ACCEPTED;
          end
          r.accepted_count = 7'(str_count);
          if (w.string_end) begin
            str_count = 0;
            str_stopped = 0;
          end
        end
        CMD_CLEAR: begin
          total = eff_rows() * len;
          for (int i = 0; i < total; i++) text_mem[i] = SPACE_CODE;
        end
        default: begin
          if (int'(w.font_column) < SCAN_COLUMNS)
            font_mem[int'(w.font_column) * FONT_CODES + int'(w.char_code)] = w.font_bits;
        end
      endcase
      predicted_pins.push_back(r);
    endfunction

    function void check_result(mtds_out_t got);
      mtds_out_t want;
      if (predicted_pins.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", got);
        return;
      end
      want = predicted_pins.pop_front();
      if (got.pin_byte !== want.pin_byte || got.scan_column !== want.scan_column ||
          got.column_done !== want.column_done || got.write_status !== want.write_status ||
          got.accepted_count !== want.accepted_count) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch pin/col/done/st/cnt: exp %h/%0d/%0b/%0d/%0d got %h/%0d/%0b/%0d/%0d",
                   want.pin_byte, want.scan_column, want.column_done, want.write_status,
                   want.accepted_count, got.pin_byte, got.scan_column, got.column_done,
                   got.write_status, got.accepted_count);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  mtds_in_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  mtds_out_t   out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  pin_scoreboard sb;
  int gap_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  multiplexed_text_display_scanner u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Check result words and pick the next stall level
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  function automatic mtds_in_t tick_word();
    mtds_in_t w;
    w = '0;
    w.command = CMD_TICK;
    return w;
  endfunction

  function automatic mtds_in_t write_word(logic [5:0] col, logic [2:0] row, logic [5:0] code,
                                          logic last);
    mtds_in_t w;
    w = '0;
    w.command = CMD_WRITE;
    w.text_column = col;
    w.text_row = row;
    w.char_code = code;
    w.string_end = last;
    return w;
  endfunction

  function automatic mtds_in_t font_word(logic [2:0] fcol, logic [5:0] code, logic [6:0] bits);
    mtds_in_t w;
    w = '0;
    w.command = CMD_FONT;
    w.font_column = fcol;
    w.char_code = code;
    w.font_bits = bits;
    return w;
  endfunction

  function automatic mtds_in_t clear_word();
    mtds_in_t w;
    w = '0;
    w.command = CMD_CLEAR;
    return w;
  endfunction

  task automatic send_word(mtds_in_t w);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_word(w);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  // Hold input idle until every predicted word has come out
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.predicted_pins.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic send_string(output int sent);
    int len, rows, n, col, row, code;
    bit last;
    len = sb.row_len();
    rows = sb.eff_rows();
    n = ($urandom_range(99) < 5) ? $urandom_range(40, 70) : $urandom_range(1, 10);
    col = ($urandom_range(99) < 25) ? $urandom_range(0, 63) : $urandom_range(0, len - 1);
    row = ($urandom_range(99) < 15) ? $urandom_range(0, 7) : $urandom_range(0, rows - 1);
    for (int i = 0; i < n; i++) begin
      code = ($urandom_range(99) < 6) ? 0 : $urandom_range(1, 63);
      // drop the end marker now and then so the next string runs on
      last = (i == n - 1) && ($urandom_range(99) >= 10);
      send_word(write_word(6'(col), 3'(row), 6'(code), last));
    end
    sent = n;
  endtask

  task automatic run_random(int count);
    int done, pick, burst;
    mtds_in_t w;
    logic [31:0] raw;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        burst = $urandom_range(1, 40);
        repeat (burst) send_word(tick_word());
        done += burst;
      end else if (pick < 75) begin
        send_string(burst);
        done += burst;
      end else if (pick < 88) begin
        raw = $urandom;
        send_word(font_word(raw[2:0], raw[8:3], raw[15:9]));
        done++;
      end else if (pick < 90) begin
        send_word(clear_word());
        done++;
      end else begin
        raw = $urandom;
        w = write_word(raw[5:0], raw[8:6], raw[14:9], raw[15]);
        w.command = raw[17:16];
        w.font_column = raw[20:18];
        w.font_bits = raw[27:21];
        send_word(w);
        done++;
      end
    end
  endtask

  task automatic run_directed();
    send_word(write_word(6'd0, 3'd0, 6'd63, 1'b0));
    send_word(write_word(6'd0, 3'd0, 6'd1, 1'b0));
    send_word(write_word(6'd0, 3'd0, 6'd0, 1'b0));
    send_word(write_word(6'd0, 3'd0, 6'd5, 1'b1));
    send_word(write_word(6'd63, 3'd6, 6'd45, 1'b0));
    send_word(write_word(6'd63, 3'd6, 6'd46, 1'b1));
    send_word(write_word(6'd0, 3'd7, 6'd10, 1'b1));
    send_word(write_word(6'd10, 3'd3, 6'd0, 1'b1));
    send_word(font_word(3'd7, 6'd63, 7'h7F));
    send_word(font_word(3'd5, 6'd0, 7'h00));
    send_word(font_word(3'd4, 6'd63, 7'h7F));
    send_word(font_word(3'd0, 6'd32, 7'h00));
    repeat (6) send_word(tick_word());
    send_word(clear_word());
    repeat (4) send_word(tick_word());
    send_word(write_word(6'd63, 3'd0, 6'd63, 1'b1));
    send_word(tick_word());
  endtask

  initial begin
    logic [31:0] rc_set [PHASES] = '{7, 1, 3, 0, 7, 2, 5, 1};
    logic [31:0] ipr_set [PHASES] = '{8, 1, 2, 0, 15, 1, 4, 0};
    logic [31:0] unused_set [PHASES] = '{32'hFF, 32'hA5, 32'h5A, 32'h00,
                                         32'hC3, 32'hFF, 32'h00, 32'h81};
    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) drain();
      case (p % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 47; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 47; end
        default: begin gap_pct = 19; stall_pct = 19; end
      endcase
      write_reg(REG_ROW_COUNT, rc_set[p]);
      write_reg(REG_INDICATORS, ipr_set[p]);
      write_reg(REG_UNUSED, unused_set[p]);
      if (p == 0) begin
        // every font entry must be defined before the first tick
        for (int c = 0; c < SCAN_COLUMNS; c++)
          for (int k = 0; k < FONT_CODES; k++)
            send_word(font_word(3'(c), 6'(k), 7'($urandom_range(0, 127))));
        run_directed();
      end
      run_random(PHASE_WORDS);
    end
    drain();
    if (sb.mismatches == 0 && sb.predicted_pins.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
